// ===== design/permission_checked_memory_dirty_track_defines.svh =====
// assertion macros for the permission checked memory block
// used by the port checker; needs clk and rst in scope
`ifndef PERMISSION_CHECKED_MEMORY_DIRTY_TRACK_DEFINES_SVH
`define PERMISSION_CHECKED_MEMORY_DIRTY_TRACK_DEFINES_SVH

// same-cycle implication
`define PCMDT_CHK_NOW(name, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pcmdt check failed");

// next-cycle implication
`define PCMDT_CHK_NEXT(name, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pcmdt check failed");

`endif

// ===== design/pcmdt_pkg.sv =====
// shared types, codes and sizes of the permission checked memory
// no dependencies
package pcmdt_pkg;

  localparam int MEM_BYTES         = 1048576;
  localparam int DIRTY_BLOCK_BYTES = 4096;
  localparam int MAX_ACCESS_BYTES  = 8;

  localparam int MEM_AW       = $clog2(MEM_BYTES);
  localparam int BLK_SH       = $clog2(DIRTY_BLOCK_BYTES);
  localparam int TRACK_BLOCKS = MEM_BYTES / DIRTY_BLOCK_BYTES;
  localparam int TRK_AW       = MEM_AW - BLK_SH;
  localparam int IDX_W        = (MAX_ACCESS_BYTES > 1) ? $clog2(MAX_ACCESS_BYTES) : 1;
  localparam int CFG_W        = 21;
  localparam int CNT_W        = 9;

  // request codes
  localparam logic [2:0] REQ_READ  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_ALLOC = 3'd2;
  localparam logic [2:0] REQ_SETP  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_PERM    = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;
  localparam logic [2:0] ST_BADLEN  = 3'd5;

  // permission bits
  localparam logic [3:0] PERM_WRITE = 4'h2;
  localparam logic [3:0] PERM_READ  = 4'h4;
  localparam logic [3:0] PERM_RAW   = 4'h8;
  localparam logic [21:0] ALIGN_MASK = 22'hf;

  // configuration register indexes
  localparam logic CFG_MEM_SIZE  = 1'b0;
  localparam logic CFG_HEAP_BASE = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] address;
    logic [20:0] length;
    logic [63:0] write_data;
    logic [3:0]  perm_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_data;
    logic [20:0] alloc_base;
    logic [8:0]  dirty_count;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic clr_step;
    logic decide;
    logic rd_issue;
    logic eval;
    logic wr_step;
    logic mark;
    logic mark_hi;
    logic fill_step;
    logic dclr_step;
    logic load_res;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_access;
    logic is_write;
    logic is_clear;
    logic pre_fail;
    logic fill_req;
    logic fill_empty;
    logic last_idx;
    logic perm_fault;
    logic fill_last;
    logic dclr_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/pcmdt_ctrl.sv =====
// request sequencer of the permission checked memory
// depends on pcmdt_pkg
module pcmdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcmdt_pkg::dp_stat_t stat,
  output pcmdt_pkg::dp_cmd_t  cmd
);
  import pcmdt_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_DECIDE = 12'b000000000100,
    S_SCAN   = 12'b000000001000,
    S_DRAIN  = 12'b000000010000,
    S_EVAL   = 12'b000000100000,
    S_WRITE  = 12'b000001000000,
    S_MARK0  = 12'b000010000000,
    S_MARK1  = 12'b000100000000,
    S_FILL   = 12'b001000000000,
    S_RES    = 12'b010000000000,
    S_DCLR   = 12'b100000000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load_req = in_valid;
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.pre_fail) state_next = S_RES;
        else if (stat.is_access) state_next = S_SCAN;
        else if (stat.is_clear) state_next = S_DCLR;
        else if (stat.fill_req && !stat.fill_empty) state_next = S_FILL;
        else state_next = S_RES;
      end
      S_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (stat.last_idx) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.is_write && !stat.perm_fault) state_next = S_WRITE;
        else state_next = S_RES;
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (stat.last_idx) state_next = S_MARK0;
      end
      S_MARK0: begin
        cmd.mark = 1'b1;
        state_next = S_MARK1;
      end
      S_MARK1: begin
        cmd.mark = 1'b1;
        cmd.mark_hi = 1'b1;
        state_next = S_RES;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) state_next = S_RES;
      end
      S_DCLR: begin
        cmd.dclr_step = 1'b1;
        if (stat.dclr_last) state_next = S_RES;
      end
      S_RES: begin
        cmd.load_res = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/pcmdt_dp.sv =====
// datapath: byte and permission memories, checks, allocator, dirty tracking
// depends on pcmdt_pkg
module pcmdt_dp (
  input  logic                clk,
  input  logic                rst,
  input  pcmdt_pkg::dp_cmd_t  cmd,
  output pcmdt_pkg::dp_stat_t stat,
  input  pcmdt_pkg::req_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcmdt_pkg::rsp_t     out_data,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [20:0]         cfg_data
);
  import pcmdt_pkg::*;

  logic [7:0] byte_mem [MEM_BYTES];
  logic [3:0] perm_mem [MEM_BYTES];
  logic       dirty_mem [TRACK_BLOCKS];

  req_t              req_q;
  logic [CFG_W-1:0]  mem_size;
  logic [CFG_W-1:0]  alloc_ptr;
  logic [CFG_W-1:0]  abase_q;
  logic [2:0]        st_q;
  logic [MEM_AW-1:0] clr_addr;
  logic              clr_done;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  cap_idx;
  logic              rd_pend;
  logic [7:0]        byte_rd;
  logic [3:0]        perm_rd;
  logic [3:0]        perm_buf [MAX_ACCESS_BYTES];
  logic [63:0]       rdata_acc;
  logic [MEM_AW-1:0] fill_addr;
  logic [CFG_W-1:0]  fill_rem;
  logic [3:0]        fill_val;
  logic [TRK_AW-1:0] dclr_addr;
  logic              trk_rd;
  logic [CNT_W-1:0]  dcount;

  logic [CFG_W-1:0]  lim;
  logic [32:0]       acc_end;
  logic [21:0]       aligned;
  logic [22:0]       ap_end;
  logic              badlen, acc_range, perm_range, full, overrun;
  logic [MEM_AW-1:0] mem_base, rd_addr, last_addr, waddr;
  logic [TRK_AW-1:0] blk_lo, blk_hi, trk_raddr, trk_waddr;
  logic              trk_we, trk_wbit, mark_new;
  logic              fault, raw_any;
  logic [3:0]        need;
  logic              bwe, pwe;
  logic [7:0]        wbyte;
  logic [3:0]        wperm;

  // limits and range checks
  assign lim = (mem_size < CFG_W'(MEM_BYTES)) ? mem_size : CFG_W'(MEM_BYTES);
  assign acc_end = {1'b0, req_q.address} + 33'(req_q.length);
  assign aligned = (22'(req_q.length) + ALIGN_MASK) & ~ALIGN_MASK;
  assign ap_end = 23'(alloc_ptr) + 23'(aligned);
  assign badlen = (req_q.length == '0) || (req_q.length > 21'(MAX_ACCESS_BYTES));
  assign acc_range = acc_end > 33'(lim);
  assign perm_range = acc_end >= 33'(lim);
  assign full = alloc_ptr >= lim;
  assign overrun = ap_end >= 23'(lim);

  assign mem_base = req_q.address[MEM_AW-1:0];
  assign rd_addr = mem_base + MEM_AW'(idx);
  assign last_addr = mem_base + MEM_AW'(req_q.length - 21'd1);

  // dirty blocks of the first and last written byte
  assign blk_lo = mem_base[MEM_AW-1:BLK_SH];
  assign blk_hi = last_addr[MEM_AW-1:BLK_SH];
  assign mark_new = cmd.mark && !trk_rd && !(cmd.mark_hi && (blk_hi == blk_lo));
  assign trk_raddr = (cmd.mark && !cmd.mark_hi) ? blk_hi : blk_lo;

  // permission scan over captured bytes
  always_comb begin
    fault = 1'b0;
    raw_any = 1'b0;
    need = (req_q.req_type == REQ_READ) ? PERM_READ : PERM_WRITE;
    for (int i = 0; i < MAX_ACCESS_BYTES; i++) begin
      if (21'(i) < req_q.length) begin
        if ((perm_buf[i] & need) == 4'h0) fault = 1'b1;
        if ((perm_buf[i] & PERM_RAW) != 4'h0) raw_any = 1'b1;
      end
    end
  end

  // status to controller
  always_comb begin
    stat = '0;
    stat.clr_done = clr_done;
    stat.is_access = (req_q.req_type == REQ_READ) || (req_q.req_type == REQ_WRITE);
    stat.is_write = (req_q.req_type == REQ_WRITE);
    stat.is_clear = (req_q.req_type == REQ_CLEAR);
    stat.fill_req = (req_q.req_type == REQ_ALLOC) || (req_q.req_type == REQ_SETP);
    case (req_q.req_type)
      REQ_READ, REQ_WRITE: stat.pre_fail = badlen || acc_range;
      REQ_ALLOC:           stat.pre_fail = full || overrun;
      REQ_SETP:            stat.pre_fail = perm_range;
      default:             stat.pre_fail = 1'b0;
    endcase
    stat.fill_empty = (req_q.req_type == REQ_ALLOC) ? (aligned == '0) : (req_q.length == '0);
    stat.last_idx = (idx == IDX_W'(req_q.length - 21'd1));
    stat.perm_fault = fault;
    stat.fill_last = (fill_rem == CFG_W'(1));
    stat.dclr_last = (dclr_addr == {TRK_AW{1'b1}});
    stat.out_free = !out_valid || out_ready;
  end

  // memory write port select
  always_comb begin
    bwe = 1'b0;
    pwe = 1'b0;
    waddr = rd_addr;
    wbyte = req_q.write_data[{idx, 3'b000} +: 8];
    wperm = (perm_buf[idx] & ~PERM_RAW) | PERM_READ;
    if (cmd.clr_step) begin
      bwe = 1'b1;
      pwe = 1'b1;
      waddr = clr_addr;
      wbyte = '0;
      wperm = '0;
    end else if (cmd.wr_step) begin
      bwe = 1'b1;
      pwe = raw_any;
    end else if (cmd.fill_step) begin
      pwe = 1'b1;
      waddr = fill_addr;
      wperm = fill_val;
    end
  end

  // dirty memory write port select
  always_comb begin
    trk_we = 1'b0;
    trk_waddr = blk_lo;
    trk_wbit = 1'b0;
    if (cmd.clr_step) begin
      trk_we = 1'b1;
      trk_waddr = clr_addr[TRK_AW-1:0];
    end else if (cmd.dclr_step) begin
      trk_we = 1'b1;
      trk_waddr = dclr_addr;
    end else if (mark_new) begin
      trk_we = 1'b1;
      trk_waddr = cmd.mark_hi ? blk_hi : blk_lo;
      trk_wbit = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (bwe) byte_mem[waddr] <= wbyte;
    if (pwe) perm_mem[waddr] <= wperm;
    byte_rd <= byte_mem[rd_addr];
    perm_rd <= perm_mem[rd_addr];
  end

  // dirty block memory
  always_ff @(posedge clk) begin
    if (trk_we) dirty_mem[trk_waddr] <= trk_wbit;
    trk_rd <= dirty_mem[trk_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= in_data;
      rdata_acc <= '0;
      abase_q <= '0;
    end
    if (rd_pend) begin
      perm_buf[cap_idx] <= perm_rd;
      rdata_acc[{cap_idx, 3'b000} +: 8] <= byte_rd;
    end
    cap_idx <= idx;
    if (cmd.decide) begin
      case (req_q.req_type)
        REQ_READ, REQ_WRITE: st_q <= badlen ? ST_BADLEN : (acc_range ? ST_RANGE : ST_OK);
        REQ_ALLOC: begin
          st_q <= full ? ST_FULL : (overrun ? ST_OVERRUN : ST_OK);
          abase_q <= (full || overrun) ? '0 : alloc_ptr;
          fill_addr <= alloc_ptr[MEM_AW-1:0];
          fill_rem <= aligned[CFG_W-1:0];
          fill_val <= PERM_RAW | PERM_WRITE;
        end
        REQ_SETP: begin
          st_q <= perm_range ? ST_RANGE : ST_OK;
          fill_addr <= mem_base;
          fill_rem <= req_q.length;
          fill_val <= req_q.perm_value;
        end
        default: st_q <= ST_OK;
      endcase
    end
    if (cmd.eval && fault) st_q <= ST_PERM;
    if (cmd.fill_step) begin
      fill_addr <= fill_addr + MEM_AW'(1);
      fill_rem <= fill_rem - CFG_W'(1);
    end
    if (cmd.load_res) begin
      out_data.status <= st_q;
      out_data.read_data <= ((req_q.req_type == REQ_READ) && (st_q == ST_OK)) ? rdata_acc : '0;
      out_data.alloc_base <= abase_q;
      out_data.dirty_count <= dcount;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size <= CFG_W'(MEM_BYTES);
      alloc_ptr <= '0;
      clr_addr <= '0;
      clr_done <= 1'b0;
      idx <= '0;
      rd_pend <= 1'b0;
      dclr_addr <= '0;
      dcount <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
      // power-up clearing sweep
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + MEM_AW'(1);
        if (clr_addr == {MEM_AW{1'b1}}) clr_done <= 1'b1;
      end
      if (cmd.decide || cmd.eval) idx <= '0;
      else if (cmd.rd_issue || cmd.wr_step) idx <= idx + IDX_W'(1);
      // allocator commit and dirty clear
      if (cmd.decide && (req_q.req_type == REQ_ALLOC) && !full && !overrun) begin
        alloc_ptr <= ap_end[CFG_W-1:0];
      end
      if (cmd.decide && (req_q.req_type == REQ_CLEAR)) begin
        dcount <= '0;
      end
      // dirty memory clearing walk
      if (cmd.dclr_step) dclr_addr <= dclr_addr + TRK_AW'(1);
      // dirty marking
      if (mark_new && (dcount < CNT_W'(TRACK_BLOCKS))) dcount <= dcount + CNT_W'(1);
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MEM_SIZE:  mem_size <= cfg_data;
          CFG_HEAP_BASE: alloc_ptr <= cfg_data;
          default: ;
        endcase
      end
      // output slot
      if (cmd.load_res) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/permission_checked_memory_dirty_track.sv =====
// top level of the permission checked memory with dirty tracking
// depends on pcmdt_pkg, pcmdt_ctrl, pcmdt_dp
//
// Channels: in (valid/ready, req_t), out (valid/ready, rsp_t), cfg (valid/
// ready, index and data; always ready). Index 0 sets the memory size used
// for bounds checks, index 1 sets the heap base and reloads the allocator.
// One item is worked at a time; in_ready is high only while idle.
// The byte and permission memories (one read, one write port) read or write
// one byte per cycle. A read or write reads its n bytes and permissions; a
// permitted write then stores them and marks the dirty blocks of its first
// and last byte. A failed check or unknown request goes straight to the
// result. Clear dirty walks all 256 entries of the dirty block memory;
// allocate (rounded up to 16 bytes) and set permissions store permissions.
// The result sits in an output register; the next item is taken while it
// waits, and that item holds in its final state until the slot is free.
// Reset starts a clearing sweep over the byte, permission and dirty block
// memories; no item is taken until it ends, configuration writes still are.
module permission_checked_memory_dirty_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcmdt_pkg::req_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pcmdt_pkg::rsp_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [20:0]       cfg_data
);
  import pcmdt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  pcmdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  pcmdt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== design/pcmdt_checker.sv =====
// port checker for the permission checked memory, bound to the top level
// depends on pcmdt_pkg and the defines header
`include "permission_checked_memory_dirty_track_defines.svh"

module pcmdt_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input pcmdt_pkg::rsp_t out_data
);
  import pcmdt_pkg::*;

  // a stalled result stays
  `PCMDT_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // one item at a time
  `PCMDT_CHK_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // read data only on success
  `PCMDT_CHK_NOW(a_rdata_ok, out_valid && (out_data.read_data != '0), out_data.status == ST_OK)
  // allocation base only on success
  `PCMDT_CHK_NOW(a_abase_ok, out_valid && (out_data.alloc_base != '0), out_data.status == ST_OK)

endmodule

bind permission_checked_memory_dirty_track pcmdt_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/permission_checked_memory_dirty_track_test.sv =====
// self-checking testbench for the permission checked memory with dirty tracking
// depends on pcmdt_pkg and permission_checked_memory_dirty_track
`default_nettype none

module permission_checked_memory_dirty_track_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcmdt_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_MEM_SIZE;
  logic [20:0] cfg_data = '0;

  permission_checked_memory_dirty_track dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the guest memory, permissions and tracking state
  byte unsigned shadow_bytes [MEM_BYTES];
  logic [3:0] shadow_perms [MEM_BYTES];
  bit shadow_dirty [TRACK_BLOCKS];
  int unsigned shadow_dirty_total;
  int unsigned shadow_alloc_ptr;
  int unsigned shadow_mem_size;
  rsp_t expected_rsps [$];

  int unsigned error_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  // compute the response of one request and update the shadow state
  function automatic rsp_t memory_response(input req_t r);
    rsp_t rsp;
    longint unsigned lim, addr, len, aligned;
    bit raw;
    rsp = '0;
    rsp.status = ST_OK;
    lim = (shadow_mem_size < MEM_BYTES) ? shadow_mem_size : MEM_BYTES;
    addr = r.address;
    len = r.length;
    case (r.req_type)
      REQ_READ, REQ_WRITE: begin
        if (len == 0 || len > MAX_ACCESS_BYTES) begin
          rsp.status = ST_BADLEN;
        end else if (addr + len > lim) begin
          rsp.status = ST_RANGE;
        end else if (r.req_type == REQ_READ) begin
          for (longint unsigned i = 0; i < len; i++)
            if ((shadow_perms[addr + i] & PERM_READ) == 0) rsp.status = ST_PERM;
          if (rsp.status == ST_OK)
            for (longint unsigned i = 0; i < len; i++)
              rsp.read_data[8*i +: 8] = shadow_bytes[addr + i];
        end else begin
          raw = 1'b0;
          for (longint unsigned i = 0; i < len; i++) begin
            if ((shadow_perms[addr + i] & PERM_RAW) != 0) raw = 1'b1;
            if ((shadow_perms[addr + i] & PERM_WRITE) == 0) rsp.status = ST_PERM;
          end
          if (rsp.status == ST_OK) begin
            for (longint unsigned i = 0; i < len; i++)
              shadow_bytes[addr + i] = r.write_data[8*i +: 8];
            // every block from the first to the last written byte
            for (longint unsigned b = addr / DIRTY_BLOCK_BYTES;
                 b <= (addr + len - 1) / DIRTY_BLOCK_BYTES; b++) begin
              if (b < TRACK_BLOCKS && !shadow_dirty[b]) begin
                if (shadow_dirty_total < TRACK_BLOCKS) shadow_dirty_total++;
                shadow_dirty[b] = 1'b1;
              end
            end
            if (raw)
              for (longint unsigned i = 0; i < len; i++)
                shadow_perms[addr + i] = (shadow_perms[addr + i] & ~PERM_RAW) | PERM_READ;
          end
        end
      end
      REQ_ALLOC: begin
        aligned = (len + 15) & ~64'hf;
        if (shadow_alloc_ptr >= lim) begin
          rsp.status = ST_FULL;
        end else if (shadow_alloc_ptr + aligned >= lim) begin
          rsp.status = ST_OVERRUN;
        end else begin
          rsp.alloc_base = 21'(shadow_alloc_ptr);
          for (longint unsigned i = 0; i < aligned; i++)
            shadow_perms[shadow_alloc_ptr + i] = PERM_RAW | PERM_WRITE;
          shadow_alloc_ptr = 32'(shadow_alloc_ptr + aligned);
        end
      end
      REQ_SETP: begin
        if (addr + len >= lim) rsp.status = ST_RANGE;
        else for (longint unsigned i = 0; i < len; i++) shadow_perms[addr + i] = r.perm_value;
      end
      REQ_CLEAR: begin
        foreach (shadow_dirty[b]) shadow_dirty[b] = 1'b0;
        shadow_dirty_total = 0;
      end
      default: ;
    endcase
    rsp.dirty_count = 9'(shadow_dirty_total);
    return rsp;
  endfunction

  // send one item with a random lead-in gap
  task automatic send_item(input req_t r);
    int unsigned gap;
    gap = 0;
    while (($urandom % 100) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rsps.push_back(memory_response(r));
  endtask

  task automatic send_fields(input logic [2:0] kind, input logic [31:0] addr,
                             input logic [20:0] len, input logic [63:0] data,
                             input logic [3:0] perm);
    req_t r;
    r.req_type = kind;
    r.address = addr;
    r.length = len;
    r.write_data = data;
    r.perm_value = perm;
    send_item(r);
  endtask

  // hold off the sender until every response is back
  task automatic drain_responses();
    in_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [20:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MEM_SIZE) begin
      shadow_mem_size = 32'(value);
    end else begin
      shadow_alloc_ptr = 32'(value);
    end
  endtask

  // response checker and random output stall
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected item", out_data.read_data, 64'd0);
      end else begin
        rsp_t want;
        want = expected_rsps.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.alloc_base !== want.alloc_base)
          report_mismatch("alloc_base", 64'(out_data.alloc_base), 64'(want.alloc_base));
        if (out_data.dirty_count !== want.dirty_count)
          report_mismatch("dirty_count", 64'(out_data.dirty_count),
                          64'(want.dirty_count));
      end
    end
    out_ready <= (($urandom % 100) >= stall_pct);
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // extremes of the fields, every request and the named corner cases
  task automatic test_directed();
    send_fields(REQ_READ, 0, 0, 0, 0);                          // bad length zero
    send_fields(REQ_WRITE, 0, 9, '1, 0);                        // bad length nine
    send_fields(REQ_READ, 32'hffff_ffff, 21'h1f_ffff, '1, 4'hf);
    send_fields(REQ_READ, 32'hffff_ffff, 8, 0, 0);              // out of range
    send_fields(REQ_READ, 0, 1, 0, 0);                          // no permission
    send_fields(REQ_ALLOC, 0, 0, 0, 0);                         // empty allocate
    send_fields(REQ_ALLOC, 0, 1, 0, 0);
    send_fields(REQ_ALLOC, 0, 17, 0, 0);
    send_fields(REQ_READ, 0, 8, 0, 0);                          // write-only area
    send_fields(REQ_WRITE, 4, 8, 64'h0123_4567_89ab_cdef, 0);   // read-after-write
    send_fields(REQ_READ, 4, 8, 0, 0);
    send_fields(REQ_READ, 2, 4, 0, 0);
    send_fields(REQ_SETP, 4092, 8, 0, PERM_READ | PERM_WRITE);  // across a block edge
    send_fields(REQ_WRITE, 4092, 8, '1, 0);
    send_fields(REQ_READ, 4093, 7, 0, 0);
    send_fields(REQ_SETP, 64, 0, 0, 4'hf);                      // empty range
    send_fields(REQ_SETP, MEM_BYTES - 1, 1, 0, 4'hf);           // last byte unreachable
    send_fields(REQ_SETP, MEM_BYTES - 9, 8, 0, 4'hf);
    send_fields(REQ_WRITE, MEM_BYTES - 8, 8, 64'h8000_0000_0000_0001, 0);
    send_fields(REQ_READ, MEM_BYTES - 8, 8, 0, 0);
    send_fields(REQ_SETP, 200, 4096, 0, 4'h0);                  // longer range fill
    send_fields(3'd5, 0, 0, 0, 0);
    send_fields(3'd6, '1, '1, '1, '1);
    send_fields(3'd7, 0, 1, 0, 0);
    send_fields(REQ_CLEAR, 0, 0, 0, 0);
  endtask

  // allocator full and overrun at the register extremes
  task automatic test_limits();
    drain_responses();
    write_register(CFG_MEM_SIZE, 21'd1);
    write_register(CFG_HEAP_BASE, 21'd0);
    send_fields(REQ_ALLOC, 0, 0, 0, 0);
    send_fields(REQ_ALLOC, 0, 1, 0, 0);
    send_fields(REQ_READ, 0, 1, 0, 0);
    send_fields(REQ_READ, 0, 2, 0, 0);
    send_fields(REQ_SETP, 0, 0, 0, 4'hf);
    drain_responses();
    write_register(CFG_MEM_SIZE, 21'd1048576);
    write_register(CFG_HEAP_BASE, 21'd1048576);
    send_fields(REQ_ALLOC, 0, 16, 0, 0);
    drain_responses();
    write_register(CFG_HEAP_BASE, 21'd1048560);
    send_fields(REQ_ALLOC, 0, 16, 0, 0);
    send_fields(REQ_ALLOC, 0, 0, 0, 0);
  endtask

  // mostly well-formed requests inside a few blocks, with some noise
  task automatic test_random(input int unsigned count, input int unsigned send_idle,
                             input int unsigned recv_stall, input bit pause_once);
    req_t r;
    int unsigned pick, blk;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    for (int unsigned n = 0; n < count; n++) begin
      if (pause_once && n == count / 2) drain_responses();
      r.write_data = {$urandom, $urandom};
      r.perm_value = 4'($urandom_range(0, 15));
      blk = (($urandom % 100) < 80) ? $urandom_range(0, 7) : $urandom_range(0, 255);
      r.address = blk * DIRTY_BLOCK_BYTES + $urandom_range(0, 63);
      r.length = 21'($urandom_range(1, MAX_ACCESS_BYTES));
      pick = $urandom % 100;
      if (pick < 30) begin
        r.req_type = REQ_WRITE;
      end else if (pick < 60) begin
        r.req_type = REQ_READ;
      end else if (pick < 70) begin
        r.req_type = REQ_ALLOC;
        r.length = 21'($urandom_range(0, 48));
      end else if (pick < 85) begin
        r.req_type = REQ_SETP;
        r.length = (($urandom % 100) < 3) ? 21'($urandom_range(0, 4096))
                                          : 21'($urandom_range(0, 72));
        if (($urandom % 100) < 70) r.perm_value = r.perm_value | PERM_READ | PERM_WRITE;
      end else if (pick < 88) begin
        r.req_type = REQ_CLEAR;
      end else if (pick < 93) begin
        r.req_type = 3'($urandom_range(0, 1));
        r.length = 21'($urandom_range(0, 15));
      end else begin
        r.req_type = 3'($urandom_range(0, 7));
        r.address = $urandom;
        r.length = 21'($urandom_range(0, 21'h1f_ffff));
        if (r.req_type == REQ_ALLOC) r.length = 21'($urandom_range(0, 64));
      end
      send_item(r);
    end
  endtask

  initial begin
    shadow_mem_size = 1048576;
    shadow_alloc_ptr = 0;
    shadow_dirty_total = 0;
    foreach (shadow_bytes[i]) begin
      shadow_bytes[i] = 8'h00;
      shadow_perms[i] = 4'h0;
    end
    foreach (shadow_dirty[b]) shadow_dirty[b] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_register(CFG_MEM_SIZE, 21'd1048576);
    write_register(CFG_HEAP_BASE, 21'd0);
    test_directed();
    test_limits();
    drain_responses();
    write_register(CFG_MEM_SIZE, 21'd1048576);
    write_register(CFG_HEAP_BASE, 21'd0);
    test_random(380, 36, 85, 1'b1);
    drain_responses();
    write_register(CFG_MEM_SIZE, 21'd20000);
    write_register(CFG_HEAP_BASE, 21'd4096);
    test_random(380, 85, 36, 1'b0);
    drain_responses();
    write_register(CFG_MEM_SIZE, 21'($urandom_range(32768, 1048576)));
    write_register(CFG_HEAP_BASE, 21'($urandom_range(0, 16384)));
    test_random(380, 0, 0, 1'b0);
    drain_responses();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
